// ----- rtl/ttc_pkg.sv -----
// Package of the text tokenizer: widths, character codes, role and kind codes,
// the request and result records, and the character class helpers.
// No dependencies.
`default_nettype none

package ttc_pkg;

   localparam int CHAR_BITS     = 8;
   localparam int LINE_BITS     = 25;
   localparam int START_BITS    = 24;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0]            COMMENT_MASK_RESET = 3'd7;
   localparam logic                  ALLOW_PATHS_RESET  = 1'b0;
   localparam logic [START_BITS-1:0] START_LINE_RESET   = START_BITS'(1);

   localparam logic [1:0] REG_COMMENT_MASK = 2'd0;
   localparam logic [1:0] REG_ALLOW_PATHS  = 2'd1;
   localparam logic [1:0] REG_START_LINE   = 2'd2;

   localparam logic signed [LINE_BITS-1:0] LINE_MAX = {1'b0, {(LINE_BITS-1){1'b1}}};
   localparam logic [LINE_BITS-1:0]        DIR_MAX  = {1'b1, {(LINE_BITS-1){1'b0}}};

   localparam logic [CHAR_BITS-1:0] CH_NUL       = CHAR_BITS'(0);
   localparam logic [CHAR_BITS-1:0] CH_TAB       = CHAR_BITS'(9);
   localparam logic [CHAR_BITS-1:0] CH_LF        = CHAR_BITS'(10);
   localparam logic [CHAR_BITS-1:0] CH_CR        = CHAR_BITS'(13);
   localparam logic [CHAR_BITS-1:0] CH_SPACE     = CHAR_BITS'(32);
   localparam logic [CHAR_BITS-1:0] CH_DQUOTE    = CHAR_BITS'(34);
   localparam logic [CHAR_BITS-1:0] CH_POUND     = CHAR_BITS'(35);
   localparam logic [CHAR_BITS-1:0] CH_SQUOTE    = CHAR_BITS'(39);
   localparam logic [CHAR_BITS-1:0] CH_STAR      = CHAR_BITS'(42);
   localparam logic [CHAR_BITS-1:0] CH_PLUS      = CHAR_BITS'(43);
   localparam logic [CHAR_BITS-1:0] CH_MINUS     = CHAR_BITS'(45);
   localparam logic [CHAR_BITS-1:0] CH_DOT       = CHAR_BITS'(46);
   localparam logic [CHAR_BITS-1:0] CH_SLASH     = CHAR_BITS'(47);
   localparam logic [CHAR_BITS-1:0] CH_ZERO      = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0] CH_NINE      = CHAR_BITS'(57);
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A   = CHAR_BITS'(65);
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z   = CHAR_BITS'(90);
   localparam logic [CHAR_BITS-1:0] CH_BACKSLASH = CHAR_BITS'(92);
   localparam logic [CHAR_BITS-1:0] CH_UNDER     = CHAR_BITS'(95);
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A   = CHAR_BITS'(97);
   localparam logic [CHAR_BITS-1:0] CH_LOWER_E   = CHAR_BITS'(101);
   localparam logic [CHAR_BITS-1:0] CH_LOWER_I   = CHAR_BITS'(105);
   localparam logic [CHAR_BITS-1:0] CH_LOWER_L   = CHAR_BITS'(108);
   localparam logic [CHAR_BITS-1:0] CH_LOWER_N   = CHAR_BITS'(110);
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Z   = CHAR_BITS'(122);

   typedef enum logic [2:0] {
      R_WHITE   = 3'd0,
      R_COMMENT = 3'd1,
      R_QUOTE   = 3'd2,
      R_BODY    = 3'd3,
      R_ESCAPED = 3'd4
   } role_type;

   typedef enum logic [2:0] {
      K_NONE   = 3'd0,
      K_QUOTED = 3'd1,
      K_PATH   = 3'd2,
      K_IDENT  = 3'd3,
      K_WORD   = 3'd4,
      K_PUNCT  = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0]            comment_mask;
      logic                  allow_paths;
      logic [START_BITS-1:0] start_line;
   } cfg_type;

   typedef struct packed {
      logic                 classify;
      logic                 load_start;
      logic                 last;
      logic [CHAR_BITS-1:0] cur_char;
      logic [CHAR_BITS-1:0] next_char;
   } scan_cmd_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0]        out_char;
      role_type                    char_role;
      kind_type                    token_kind;
      logic                        token_first;
      logic                        token_last;
      logic signed [LINE_BITS-1:0] line_number;
      logic                        final_result;
   } rsp_payload_type;

   function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
   endfunction

   function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_ident(input logic [CHAR_BITS-1:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER;
   endfunction

   function automatic logic is_word(input logic [CHAR_BITS-1:0] c);
      return is_ident(c) || c == CH_DOT || c == CH_MINUS;
   endfunction

   function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic logic is_eol(input logic [CHAR_BITS-1:0] c);
      return c == CH_CR || c == CH_LF;
   endfunction

   function automatic logic continues(input kind_type kind, input logic [CHAR_BITS-1:0] nx);
      logic result;
      case (kind)
         K_PATH:  result = nx > CH_SPACE;
         K_IDENT: result = is_ident(nx);
         K_WORD:  result = is_word(nx);
         default: result = (nx > CH_SPACE) && !is_word(nx);
      endcase
      return result;
   endfunction

   function automatic logic [CHAR_BITS-1:0] keyword_char(input logic [1:0] idx);
      logic [CHAR_BITS-1:0] result;
      case (idx)
         2'd0:    result = CH_LOWER_L;
         2'd1:    result = CH_LOWER_I;
         2'd2:    result = CH_LOWER_N;
         default: result = CH_LOWER_E;
      endcase
      return result;
   endfunction

   function automatic logic [LINE_BITS-1:0] add_digit(input logic [LINE_BITS-1:0] v,
                                                      input logic [CHAR_BITS-1:0] c);
      logic [LINE_BITS+3:0] wide;
      logic [LINE_BITS+3:0] sum;
      wide = (LINE_BITS+4)'(v);
      sum  = (wide << 3) + (wide << 1) + (LINE_BITS+4)'(c - CH_ZERO);
      return (sum > (LINE_BITS+4)'(DIR_MAX)) ? DIR_MAX : LINE_BITS'(sum);
   endfunction

   function automatic logic signed [LINE_BITS-1:0] clamp_start(input logic [START_BITS-1:0] s);
      logic [34:0] wide;
      wide = 35'(s);
      return (wide > 35'(LINE_MAX)) ? LINE_MAX : LINE_BITS'(s);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ttc_if.sv -----
// Request and result channel interfaces of the text tokenizer.
// Depends on ttc_pkg for the field widths.
`default_nettype none

interface ttc_req_if import ttc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] text_char;
   logic                 end_of_text;

   modport source (output valid, output text_char, output end_of_text, input ready);
   modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface ttc_rsp_if import ttc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [CHAR_BITS-1:0]        out_char;
   logic [2:0]                  char_role;
   logic [2:0]                  token_kind;
   logic                        token_first;
   logic                        token_last;
   logic signed [LINE_BITS-1:0] line_number;
   logic                        final_result;

   modport source (output valid, output out_char, output char_role, output token_kind,
                   output token_first, output token_last, output line_number,
                   output final_result, input ready);
   modport sink (input valid, input out_char, input char_role, input token_kind,
                 input token_first, input token_last, input line_number,
                 input final_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/ttc_csr.sv -----
// Configuration registers of the text tokenizer behind an APB-style port.
// Depends on ttc_pkg for the register indexes and the configuration record.
`default_nettype none

module ttc_csr import ttc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (paddr[3:2])
            REG_COMMENT_MASK: cfg_in.comment_mask = pwdata[2:0];
            REG_ALLOW_PATHS:  cfg_in.allow_paths  = pwdata[0];
            REG_START_LINE:   cfg_in.start_line   = pwdata[START_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_COMMENT_MASK: prdata = CSR_DATA_BITS'(cfg_ff.comment_mask);
         REG_ALLOW_PATHS:  prdata = CSR_DATA_BITS'(cfg_ff.allow_paths);
         REG_START_LINE:   prdata = CSR_DATA_BITS'(cfg_ff.start_line);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comment_mask <= COMMENT_MASK_RESET;
         cfg_ff.allow_paths  <= ALLOW_PATHS_RESET;
         cfg_ff.start_line   <= START_LINE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ttc_scanner.sv -----
// Scan state machine of the text tokenizer: classifies one character against
// its lookahead and keeps the mode, quote mark, line counter and directive state.
// Depends on ttc_pkg for character codes, records and class helpers.
`default_nettype none

module ttc_scanner import ttc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  cfg_type      cfg,
   input  scan_cmd_type cmd,
   output rsp_payload_type result
);

   typedef enum logic [3:0] {
      M_WS        = 4'd0,
      M_LCOM      = 4'd1,
      M_PKEY      = 4'd2,
      M_PSKIP     = 4'd3,
      M_PDIG      = 4'd4,
      M_BOPEN     = 4'd5,
      M_BLOCK     = 4'd6,
      M_BCLOSE    = 4'd7,
      M_QUOTE     = 4'd8,
      M_ESC       = 4'd9,
      M_TOK_PATH  = 4'd10,
      M_TOK_IDENT = 4'd11,
      M_TOK_WORD  = 4'd12,
      M_TOK_PUNCT = 4'd13
   } mode_type;

   mode_type                    mode_ff, mode_in, mode_pre, mode_cls;
   logic [CHAR_BITS-1:0]        quote_ff, quote_in, quote_cls;
   logic signed [LINE_BITS-1:0] line_ff, line_in, line_cur, line_cls;
   logic [LINE_BITS-1:0]        dval_ff, dval_in, dval_cls;
   logic                        dneg_ff, dneg_in, dneg_cls;
   logic [2:0]                  kw_ff, kw_in, kw_cls;
   logic signed [LINE_BITS-1:0] dir_line;
   logic                        load_dir;
   logic                        bump;
   role_type                    role;
   kind_type                    kind;
   logic                        first;
   logic                        last;
   logic [CHAR_BITS-1:0]        c;
   logic [CHAR_BITS-1:0]        nx;
   logic                        nend;

   assign c    = cmd.cur_char;
   assign nx   = cmd.next_char;
   assign nend = cmd.last;
   assign dir_line = dneg_ff ? {LINE_BITS{1'b1}}
                             : $signed(dval_ff - {{(LINE_BITS-1){1'b0}}, 1'b1});

   always_comb begin
      mode_pre  = mode_ff;
      load_dir  = 1'b0;
      if ((mode_ff == M_LCOM || mode_ff == M_PKEY || mode_ff == M_PSKIP ||
           mode_ff == M_PDIG) && is_eol(c)) begin
         load_dir = (mode_ff == M_PSKIP || mode_ff == M_PDIG);
         mode_pre = M_WS;
      end

      mode_cls  = mode_pre;
      quote_cls = quote_ff;
      dval_cls  = dval_ff;
      dneg_cls  = dneg_ff;
      kw_cls    = kw_ff;
      role      = R_COMMENT;
      kind      = K_NONE;
      first     = 1'b0;
      last      = 1'b0;
      bump      = 1'b0;

      unique case (mode_pre)
         M_TOK_PATH, M_TOK_IDENT, M_TOK_WORD, M_TOK_PUNCT: begin
            role = R_BODY;
            case (mode_pre)
               M_TOK_PATH:  kind = K_PATH;
               M_TOK_IDENT: kind = K_IDENT;
               M_TOK_WORD:  kind = K_WORD;
               default:     kind = K_PUNCT;
            endcase
            if (nend || !continues(kind, nx)) begin
               last     = 1'b1;
               mode_cls = M_WS;
            end
         end
         M_WS: begin
            if (c <= CH_SPACE) begin
               role = R_WHITE;
               bump = (c == CH_LF);
            end else if (cfg.comment_mask[0] && c == CH_POUND) begin
               mode_cls = M_PKEY;
               kw_cls   = 3'd0;
            end else if (cfg.comment_mask[1] && c == CH_SLASH && !nend && nx == CH_SLASH) begin
               mode_cls = M_LCOM;
            end else if (cfg.comment_mask[2] && c == CH_SLASH && !nend && nx == CH_STAR) begin
               mode_cls = M_BOPEN;
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
               role      = R_QUOTE;
               kind      = K_QUOTED;
               first     = 1'b1;
               quote_cls = c;
               last      = nend;
               mode_cls  = nend ? M_WS : M_QUOTE;
            end else begin
               if (cfg.allow_paths) begin
                  kind = K_PATH;
               end else if (is_alpha(c) || c == CH_UNDER) begin
                  kind = K_IDENT;
               end else if (is_word(c)) begin
                  kind = K_WORD;
               end else begin
                  kind = K_PUNCT;
               end
               role  = R_BODY;
               first = 1'b1;
               if (nend || !continues(kind, nx)) begin
                  last     = 1'b1;
                  mode_cls = M_WS;
               end else begin
                  case (kind)
                     K_PATH:  mode_cls = M_TOK_PATH;
                     K_IDENT: mode_cls = M_TOK_IDENT;
                     K_WORD:  mode_cls = M_TOK_WORD;
                     default: mode_cls = M_TOK_PUNCT;
                  endcase
               end
            end
         end
         M_QUOTE: begin
            kind = K_QUOTED;
            if (c == quote_ff) begin
               role     = R_QUOTE;
               last     = 1'b1;
               mode_cls = M_WS;
            end else if (c == CH_BACKSLASH && !nend) begin
               role     = R_BODY;
               mode_cls = M_ESC;
            end else begin
               role = R_BODY;
               last = nend;
            end
         end
         M_ESC: begin
            role     = R_ESCAPED;
            kind     = K_QUOTED;
            last     = nend;
            mode_cls = M_QUOTE;
         end
         M_PKEY: begin
            if (kw_ff == 3'd0 && is_blank(c)) begin
               mode_cls = M_PKEY;
            end else if (!kw_ff[2] && c == keyword_char(kw_ff[1:0])) begin
               kw_cls = kw_ff + 3'd1;
               if (kw_ff == 3'd3) begin
                  mode_cls = M_PSKIP;
                  dval_cls = '0;
                  dneg_cls = 1'b0;
               end
            end else begin
               mode_cls = M_LCOM;
            end
         end
         M_PSKIP: begin
            if (is_blank(c)) begin
               mode_cls = M_PSKIP;
            end else if (c == CH_MINUS) begin
               dneg_cls = 1'b1;
               mode_cls = M_PDIG;
            end else if (c == CH_PLUS) begin
               mode_cls = M_PDIG;
            end else if (is_digit(c)) begin
               dval_cls = add_digit(dval_ff, c);
               mode_cls = M_PDIG;
            end else begin
               load_dir = 1'b1;
               mode_cls = M_LCOM;
            end
         end
         M_PDIG: begin
            if (is_digit(c)) begin
               dval_cls = add_digit(dval_ff, c);
            end else begin
               load_dir = 1'b1;
               mode_cls = M_LCOM;
            end
         end
         M_BOPEN: begin
            mode_cls = M_BLOCK;
         end
         M_BLOCK: begin
            bump = (c == CH_LF);
            if (c == CH_STAR && !nend && nx == CH_SLASH) begin
               mode_cls = M_BCLOSE;
            end
         end
         M_BCLOSE: begin
            mode_cls = M_WS;
         end
         default: begin
            mode_cls = M_LCOM;
         end
      endcase

      line_cur = load_dir ? dir_line : line_ff;
      line_cls = (bump && line_cur < LINE_MAX) ? line_cur + LINE_BITS'(1) : line_cur;

      mode_in  = mode_ff;
      quote_in = quote_ff;
      dval_in  = dval_ff;
      dneg_in  = dneg_ff;
      kw_in    = kw_ff;
      line_in  = line_ff;
      if (cmd.classify && cmd.last) begin
         mode_in  = M_WS;
         quote_in = CH_NUL;
         dval_in  = '0;
         dneg_in  = 1'b0;
         kw_in    = 3'd0;
         line_in  = clamp_start(cfg.start_line);
      end else if (cmd.classify) begin
         mode_in  = mode_cls;
         quote_in = quote_cls;
         dval_in  = dval_cls;
         dneg_in  = dneg_cls;
         kw_in    = kw_cls;
         line_in  = line_cls;
      end else if (cmd.load_start) begin
         line_in = clamp_start(cfg.start_line);
      end
   end

   always_comb begin
      result.out_char     = c;
      result.char_role    = role;
      result.token_kind   = kind;
      result.token_first  = first;
      result.token_last   = last;
      result.line_number  = line_cur;
      result.final_result = nend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_WS;
         quote_ff <= CH_NUL;
         line_ff  <= clamp_start(START_LINE_RESET);
         dval_ff  <= '0;
         dneg_ff  <= 1'b0;
         kw_ff    <= 3'd0;
      end else begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         line_ff  <= line_in;
         dval_ff  <= dval_in;
         dneg_ff  <= dneg_in;
         kw_ff    <= kw_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ttc_rsp_queue.sv -----
// Two-entry result queue that drives the result channel of the text tokenizer.
// Depends on ttc_pkg for the result record and on ttc_rsp_if.
`default_nettype none

module ttc_rsp_queue import ttc_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  rsp_payload_type push_data,
   output logic           full,
   ttc_rsp_if.source      rsp_chan
);

   rsp_payload_type entry_ff [2];
   logic            head_ff, head_in;
   logic [1:0]      fill_ff, fill_in;
   logic            pop;
   logic            wr_idx;
   rsp_payload_type head_data;

   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign full      = fill_ff[1];
   assign wr_idx    = head_ff ^ fill_ff[0];
   assign head_data = entry_ff[head_ff];
   assign fill_in   = fill_ff + 2'(push) - 2'(pop);
   assign head_in   = head_ff ^ pop;

   assign rsp_chan.valid        = (fill_ff != 2'd0);
   assign rsp_chan.out_char     = head_data.out_char;
   assign rsp_chan.char_role    = head_data.char_role;
   assign rsp_chan.token_kind   = head_data.token_kind;
   assign rsp_chan.token_first  = head_data.token_first;
   assign rsp_chan.token_last   = head_data.token_last;
   assign rsp_chan.line_number  = head_data.line_number;
   assign rsp_chan.final_result = head_data.final_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         head_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_idx] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/text_tokenizer_with_comments.sv -----
// Top level of the text tokenizer: request holding, lookahead sequencing,
// configuration registers, scan state machine and result queue.
// Depends on ttc_pkg, ttc_if, ttc_csr, ttc_scanner and ttc_rsp_queue.
`default_nettype none

// The block takes one text character per request and one request per cycle,
// unless the result queue is full or a final character is pending. Each
// character is reported one request later, once the next one is there to
// look at, so a text of N characters gives N results. The end_of_text
// request yields the held character in the cycle it is taken, and the final
// character once it has passed the pending register and the queue has room.
// The scan state machine updates its mode and line counter once per character,
// and results wait in a two-entry queue, so requests keep flowing while a
// result is still waiting to be taken. No clearing pass is needed after reset.
module text_tokenizer_with_comments import ttc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   ttc_req_if.sink                       req_chan,
   ttc_rsp_if.source                     rsp_chan,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   cfg_type              cfg;
   scan_cmd_type         cmd;
   rsp_payload_type      result;
   logic                 q_full;
   logic                 accept;
   logic                 pend_go;
   logic                 held_valid_ff, held_valid_in;
   logic                 pend_ff, pend_in;
   logic [CHAR_BITS-1:0] held_char_ff, held_char_in;
   logic [CHAR_BITS-1:0] pend_char_ff, pend_char_in;

   ttc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_chan.ready = !pend_ff && !q_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pend_go        = pend_ff && !q_full;

   always_comb begin
      cmd.classify   = pend_go || (accept && held_valid_ff);
      cmd.load_start = accept && !held_valid_ff;
      cmd.last       = pend_go;
      cmd.cur_char   = pend_go ? pend_char_ff : held_char_ff;
      cmd.next_char  = pend_go ? CH_NUL : req_chan.text_char;

      held_valid_in = held_valid_ff;
      held_char_in  = held_char_ff;
      pend_in       = pend_ff && !pend_go;
      pend_char_in  = pend_char_ff;
      if (accept) begin
         if (req_chan.end_of_text) begin
            held_valid_in = 1'b0;
            pend_in       = 1'b1;
            pend_char_in  = req_chan.text_char;
         end else begin
            held_valid_in = 1'b1;
            held_char_in  = req_chan.text_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      held_char_ff <= held_char_in;
      pend_char_ff <= pend_char_in;
   end

   ttc_scanner u_scanner (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .cmd    (cmd),
      .result (result)
   );

   ttc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.classify),
      .push_data (result),
      .full      (q_full),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- rtl/ttc_checker.sv -----
// Port-level assertions for the text tokenizer and the bind that attaches them.
// Depends on ttc_pkg and on the top level text_tokenizer_with_comments.
`default_nettype none

module ttc_checker import ttc_pkg::*; (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        req_end,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [CHAR_BITS-1:0]        rsp_char,
   input wire logic [2:0]                  rsp_role,
   input wire logic [2:0]                  rsp_kind,
   input wire logic                        rsp_first,
   input wire logic                        rsp_last,
   input wire logic signed [LINE_BITS-1:0] rsp_line,
   input wire logic                        rsp_final
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) && $stable(rsp_role) &&
      $stable(rsp_kind) && $stable(rsp_first) && $stable(rsp_last) &&
      $stable(rsp_line) && $stable(rsp_final))
      else $error("stalled result changed or was dropped");

   a_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end |=> !req_ready)
      else $error("request taken while the final character was still pending");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_untokened: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_role == R_WHITE || rsp_role == R_COMMENT) |->
      rsp_kind == K_NONE && !rsp_first && !rsp_last)
      else $error("whitespace or comment character carries token marks");

endmodule

bind text_tokenizer_with_comments ttc_checker u_ttc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_end   (req_chan.end_of_text),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_char  (rsp_chan.out_char),
   .rsp_role  (rsp_chan.char_role),
   .rsp_kind  (rsp_chan.token_kind),
   .rsp_first (rsp_chan.token_first),
   .rsp_last  (rsp_chan.token_last),
   .rsp_line  (rsp_chan.line_number),
   .rsp_final (rsp_chan.final_result)
);

`default_nettype wire
